/* rtl/rbeg_pkg.sv */
// Shared types, register indexes and fixed-point helpers for the ground-bounce integrator.
// No dependencies; used by rbeg_core and rigid_body_euler_ground_bounce_top.
package rbeg_pkg;

    // Q16.16 constants; the time step is unsigned Q0.16
    localparam logic [15:0]        DT_RESET      = 16'd1092;
    localparam logic signed [31:0] GRAVITY_Y_RST = -32'sd642908;   // -9.81
    localparam logic signed [31:0] GROUND_RST    = 32'sd32768;     // 0.5
    localparam logic signed [24:0] ONE_Q16       = 25'sd65536;     // 1.0

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_X = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_Y = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_Z = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUND    = 3'd4;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 208;
    localparam int unsigned OUT_DATA_W = 104;

    typedef struct packed {
        logic [15:0]        time_step;
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic signed [31:0] gravity_z;
        logic signed [31:0] ground_height;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] force_req;
        logic [31:0]        inverse_mass;
        logic [23:0]        damping;
        logic [16:0]        restitution;
        logic               gravity_on;
        logic               is_static;
        logic               is_dragged;
        logic signed [31:0] bottom_offset;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_force;
        logic               ground_hit;
    } result_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Product scaled down by 2^16, truncated toward zero
    function automatic logic signed [63:0] qshr(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sd65535 : 64'sd0);
        return adj >>> 16;
    endfunction

endpackage

/* rtl/rigid_body_euler_ground_bounce_top.sv */
// Top level of the semi-implicit Euler integrator with ground bounce.
// Depends on rbeg_pkg and rbeg_core; holds the configuration registers and stream ports.
//
// Usage:
//   Each request on the s_ channel is one axis component of one body; the
//   s_ channel carries the body fields in s_tdata and the axis in s_tuser.
//   Each request yields exactly one result on the m_ channel, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata, one
//   register per cycle, while no request is in flight.
// Throughput: one request per cycle while the pipeline is not stalled;
//   each of the nine register stages holds at most one multiply level
//   or one wide add with saturation.
// Reset: pending requests are dropped and the registers take their defaults
//   (dt 1092, gravity y -9.81, ground height 0.5).
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready is low; nothing is lost or repeated.
module rigid_body_euler_ground_bounce_top
    import rbeg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_wdata,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] position, [63:32] velocity, [95:64] force_req, [127:96] inverse_mass,
    // [151:128] damping, [168:152] restitution, [169] gravity_on, [170] is_static,
    // [171] is_dragged, [203:172] bottom_offset, [207:204] zero
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]             s_tuser,    // [1:0] axis
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] new_position, [63:32] new_velocity, [95:64] new_force,
    // [96] ground_hit, [103:97] zero
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    cfg_t    cfg_reg;
    item_t   item;
    result_t result;
    logic    advance;
    logic    out_valid;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_step     <= DT_RESET;
            cfg_reg.gravity_x     <= 32'sd0;
            cfg_reg.gravity_y     <= GRAVITY_Y_RST;
            cfg_reg.gravity_z     <= 32'sd0;
            cfg_reg.ground_height <= GROUND_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TIME_STEP: cfg_reg.time_step     <= cfg_wdata[15:0];
                REG_GRAVITY_X: cfg_reg.gravity_x     <= $signed(cfg_wdata);
                REG_GRAVITY_Y: cfg_reg.gravity_y     <= $signed(cfg_wdata);
                REG_GRAVITY_Z: cfg_reg.gravity_z     <= $signed(cfg_wdata);
                REG_GROUND:    cfg_reg.ground_height <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // unpack request
    always_comb begin
        item.axis          = s_tuser;
        item.position      = $signed(s_tdata[31:0]);
        item.velocity      = $signed(s_tdata[63:32]);
        item.force_req     = $signed(s_tdata[95:64]);
        item.inverse_mass  = s_tdata[127:96];
        item.damping       = s_tdata[151:128];
        item.restitution   = s_tdata[168:152];
        item.gravity_on    = s_tdata[169];
        item.is_static     = s_tdata[170];
        item.is_dragged    = s_tdata[171];
        item.bottom_offset = $signed(s_tdata[203:172]);
    end

    // pipeline moves unless a finished result is held by the receiver
    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;

    rbeg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .in_valid   (s_tvalid),
        .in_item    (item),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_result (result)
    );

    // pack result
    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, result.ground_hit, result.new_force,
                       result.new_velocity, result.new_position};

endmodule

/* rtl/rbeg_core.sv */
// Nine-stage datapath of the integrator: gravity, damping, position update and ground bounce.
// Depends on rbeg_pkg; multiplies sit in stages 1, 3, 5 and 7, each product registered before use.
module rbeg_core
    import rbeg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,          // pipeline advance
    input  logic    in_valid,
    input  item_t   in_item,
    input  cfg_t    cfg,
    output logic    out_valid,
    output result_t out_result
);

    localparam int unsigned NSTAGE = 9;

    logic [NSTAGE-1:0] valid_reg;

    // stage payloads
    item_t              item1_reg, item2_reg, item3_reg, item4_reg;
    item_t              item5_reg, item6_reg, item7_reg, item8_reg;
    logic signed [63:0] prod_fm1_reg;
    logic [39:0]        prod_dd1_reg;
    logic signed [31:0] acc2_reg;
    logic signed [24:0] factor2_reg, factor3_reg, factor4_reg;
    logic signed [63:0] prod_adt3_reg;
    logic signed [31:0] vel1_4_reg;
    logic signed [63:0] prod_vf5_reg;
    logic signed [31:0] vel2_6_reg, vel2_7_reg, vel2_8_reg;
    logic signed [63:0] prod_vdt7_reg, prod_vr7_reg;
    logic signed [31:0] pos1_8_reg, vr8_reg;
    result_t            result_reg;

    // stage combinational values
    logic signed [32:0] inv_mass_s;
    logic signed [16:0] dt_s;
    logic signed [31:0] grav_sel;
    logic               grav_add;
    logic signed [31:0] acc_next;
    logic signed [24:0] factor_next;
    logic signed [31:0] vel1_next;
    logic signed [31:0] vel2_next;
    logic signed [32:0] neg_vel2;
    logic signed [17:0] rest_s;
    logic signed [31:0] pos1_next;
    logic signed [31:0] vr_next;
    logic signed [34:0] low_point;
    logic               hit;
    result_t            result_next;

    assign inv_mass_s = $signed({1'b0, in_item.inverse_mass});
    assign dt_s       = $signed({1'b0, cfg.time_step});

    // stage 2: gravity of the item's axis, acceleration, damping factor
    always_comb begin
        unique case (item1_reg.axis)
            AXIS_X:  grav_sel = cfg.gravity_x;
            AXIS_Y:  grav_sel = cfg.gravity_y;
            AXIS_Z:  grav_sel = cfg.gravity_z;
            default: grav_sel = 32'sd0;
        endcase
        grav_add    = item1_reg.gravity_on && (item1_reg.inverse_mass != 32'd0);
        acc_next    = sat32(qshr(prod_fm1_reg)
                            + (grav_add ? 64'($signed(grav_sel)) : 64'sd0));
        factor_next = ONE_Q16 - $signed({1'b0, prod_dd1_reg[39:16]});
    end

    // stage 4: velocity from acceleration
    assign vel1_next = sat32(64'($signed(item3_reg.velocity)) + qshr(prod_adt3_reg));

    // stage 6: damped velocity; dragged bodies keep their velocity
    assign vel2_next = item5_reg.is_dragged ? item5_reg.velocity : sat32(qshr(prod_vf5_reg));

    // stage 7 operands: reversed velocity for the bounce
    assign neg_vel2 = -(33'(vel2_6_reg));
    assign rest_s   = $signed({1'b0, item6_reg.restitution});

    // stage 8: new position and bounce velocity
    assign pos1_next = item7_reg.is_dragged ? item7_reg.position
                     : sat32(64'($signed(item7_reg.position)) + qshr(prod_vdt7_reg));
    assign vr_next   = sat32(qshr(prod_vr7_reg));

    // stage 9: ground test and result select
    assign low_point = 35'(pos1_8_reg) + 35'($signed(item8_reg.bottom_offset));
    assign hit       = (item8_reg.axis == AXIS_Y) && (low_point < 35'(cfg.ground_height));

    always_comb begin
        if (item8_reg.is_static) begin
            result_next.new_position = item8_reg.position;
            result_next.new_velocity = item8_reg.velocity;
            result_next.new_force    = item8_reg.force_req;
            result_next.ground_hit   = 1'b0;
        end else if (hit) begin
            result_next.new_position = sat32(64'($signed(cfg.ground_height))
                                             - 64'($signed(item8_reg.bottom_offset)));
            result_next.new_velocity = vr8_reg;
            result_next.new_force    = 32'sd0;
            result_next.ground_hit   = 1'b1;
        end else begin
            result_next.new_position = pos1_8_reg;
            result_next.new_velocity = vel2_8_reg;
            result_next.new_force    = 32'sd0;
            result_next.ground_hit   = 1'b0;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTAGE-2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: force * inverse mass, damping * dt
            item1_reg     <= in_item;
            prod_fm1_reg  <= in_item.force_req * inv_mass_s;
            prod_dd1_reg  <= 40'(in_item.damping) * 40'(cfg.time_step);
            // stage 2
            item2_reg     <= item1_reg;
            acc2_reg      <= acc_next;
            factor2_reg   <= factor_next;
            // stage 3: acceleration * dt
            item3_reg     <= item2_reg;
            factor3_reg   <= factor2_reg;
            prod_adt3_reg <= acc2_reg * dt_s;
            // stage 4
            item4_reg     <= item3_reg;
            factor4_reg   <= factor3_reg;
            vel1_4_reg    <= vel1_next;
            // stage 5: velocity * damping factor
            item5_reg     <= item4_reg;
            prod_vf5_reg  <= vel1_4_reg * factor4_reg;
            // stage 6
            item6_reg     <= item5_reg;
            vel2_6_reg    <= vel2_next;
            // stage 7: velocity * dt, reversed velocity * restitution
            item7_reg     <= item6_reg;
            vel2_7_reg    <= vel2_6_reg;
            prod_vdt7_reg <= vel2_6_reg * dt_s;
            prod_vr7_reg  <= neg_vel2 * rest_s;
            // stage 8
            item8_reg     <= item7_reg;
            vel2_8_reg    <= vel2_7_reg;
            pos1_8_reg    <= pos1_next;
            vr8_reg       <= vr_next;
            // stage 9: result register
            result_reg    <= result_next;
        end
    end

    assign out_valid  = valid_reg[NSTAGE-1];
    assign out_result = result_reg;

endmodule
